// ===== hw/rtl/tnv_pkg.sv =====
`timescale 1ns / 1ps

package tnv_pkg;

  localparam int unsigned NODES      = 4;
  localparam int unsigned DIM        = 3;
  localparam int unsigned COORD_W    = 16;
  localparam int unsigned EDGE_W     = COORD_W + 1;
  localparam int unsigned PROD_W     = 2 * EDGE_W;
  localparam int unsigned NRM_W      = PROD_W + 1;
  localparam int unsigned MAG_W      = PROD_W;
  localparam int unsigned SQ_W       = 2 * MAG_W;
  localparam int unsigned SQSUM_W    = SQ_W + 2;
  localparam int unsigned SQ_OUT_W   = 63;
  localparam int unsigned FRAC_SHIFT = 17;
  localparam int unsigned DOT_W      = COORD_W + NRM_W;
  localparam int unsigned SUM_W      = 56;
  localparam int unsigned VOL_W      = 53;
  localparam int unsigned DIVISOR    = DIM * DIM;
  localparam int unsigned REM_W      = $clog2(DIVISOR);
  localparam int unsigned DIV_BITS   = 8;
  localparam int unsigned DIV_STEPS  = SUM_W / DIV_BITS;
  localparam int unsigned DIV_LAT    = DIV_STEPS + 2;
  localparam int unsigned FACE_DLY   = DIV_LAT + NODES;
  localparam int unsigned PIPE_LAT   = 6;

  localparam logic [1:0] FACE_FIRST = 2'd0;
  localparam logic [1:0] FACE_LAST  = 2'd3;

  typedef logic signed [COORD_W-1:0] coord_t;

  typedef struct packed {
    logic                    vld;
    logic [1:0]              idx;
    logic signed [NRM_W-1:0] nx;
    logic signed [NRM_W-1:0] ny;
    logic signed [NRM_W-1:0] nz;
    logic [SQ_OUT_W-1:0]     sq;
    logic signed [SUM_W-1:0] dot;
  } face_t;

  typedef struct packed {
    logic                    vld;
    logic signed [VOL_W-1:0] vol;
    logic                    bad;
  } vol_t;

endpackage

// ===== hw/rtl/tnv_face_pipe.sv =====
`timescale 1ns / 1ps

module tnv_face_pipe (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            vld_i,
  input  logic [1:0]      face_i,
  input  tnv_pkg::coord_t node_i [tnv_pkg::NODES][tnv_pkg::DIM],
  output tnv_pkg::face_t  face_o
);
  import tnv_pkg::*;

  logic [PIPE_LAT-1:0] vld_q;
  logic [1:0]          idx_q [PIPE_LAT];

  logic signed [EDGE_W-1:0]  ea_d [DIM];
  logic signed [EDGE_W-1:0]  eb_d [DIM];
  coord_t                    pc_d [DIM];
  logic signed [EDGE_W-1:0]  ea_q [DIM];
  logic signed [EDGE_W-1:0]  eb_q [DIM];
  coord_t                    pc1_q [DIM];
  logic signed [PROD_W-1:0]  pr_q [2*DIM];
  coord_t                    pc2_q [DIM];
  logic signed [NRM_W-1:0]   n3_q [DIM];
  coord_t                    pc3_q [DIM];
  logic signed [NRM_W-1:0]   n4_q [DIM];
  logic [MAG_W-1:0]          mag_q [DIM];
  coord_t                    pc4_q [DIM];
  logic signed [NRM_W-1:0]   n5_q [DIM];
  logic [SQ_W-1:0]           sq_q [DIM];
  logic signed [DOT_W-1:0]   dp_q [DIM];
  logic signed [NRM_W-1:0]   n6_q [DIM];
  logic [SQ_OUT_W-1:0]       sqo_q;
  logic signed [SUM_W-1:0]   dot_q;
  logic [SQSUM_W-1:0]        sqsum;

  // edges of the selected face and the corner opposite it
  always_comb begin
    for (int c = 0; c < DIM; c++) begin
      ea_d[c] = '0;
      eb_d[c] = '0;
      pc_d[c] = '0;
    end
    unique case (face_i)
      2'd0: begin
        for (int c = 0; c < DIM; c++) begin
          ea_d[c] = EDGE_W'(node_i[2][c]) - EDGE_W'(node_i[3][c]);
          eb_d[c] = EDGE_W'(node_i[1][c]) - EDGE_W'(node_i[3][c]);
          pc_d[c] = node_i[0][c];
        end
      end
      2'd1: begin
        for (int c = 0; c < DIM; c++) begin
          ea_d[c] = EDGE_W'(node_i[0][c]) - EDGE_W'(node_i[3][c]);
          eb_d[c] = EDGE_W'(node_i[2][c]) - EDGE_W'(node_i[3][c]);
          pc_d[c] = node_i[1][c];
        end
      end
      2'd2: begin
        for (int c = 0; c < DIM; c++) begin
          ea_d[c] = EDGE_W'(node_i[0][c]) - EDGE_W'(node_i[1][c]);
          eb_d[c] = EDGE_W'(node_i[3][c]) - EDGE_W'(node_i[1][c]);
          pc_d[c] = node_i[2][c];
        end
      end
      2'd3: begin
        for (int c = 0; c < DIM; c++) begin
          ea_d[c] = EDGE_W'(node_i[2][c]) - EDGE_W'(node_i[1][c]);
          eb_d[c] = EDGE_W'(node_i[0][c]) - EDGE_W'(node_i[1][c]);
          pc_d[c] = node_i[3][c];
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[PIPE_LAT-2:0], vld_i};
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q[0] <= face_i;
    for (int s = 1; s < PIPE_LAT; s++) begin
      idx_q[s] <= idx_q[s-1];
    end
    for (int c = 0; c < DIM; c++) begin
      ea_q[c]  <= ea_d[c];
      eb_q[c]  <= eb_d[c];
      pc1_q[c] <= pc_d[c];
      pc2_q[c] <= pc1_q[c];
      pc3_q[c] <= pc2_q[c];
      pc4_q[c] <= pc3_q[c];
    end
    // cross product terms
    pr_q[0] <= ea_q[1] * eb_q[2];
    pr_q[1] <= ea_q[2] * eb_q[1];
    pr_q[2] <= ea_q[2] * eb_q[0];
    pr_q[3] <= ea_q[0] * eb_q[2];
    pr_q[4] <= ea_q[0] * eb_q[1];
    pr_q[5] <= ea_q[1] * eb_q[0];
    for (int c = 0; c < DIM; c++) begin
      n3_q[c]  <= NRM_W'(pr_q[2*c]) - NRM_W'(pr_q[2*c+1]);
      n4_q[c]  <= n3_q[c];
      mag_q[c] <= n3_q[c][NRM_W-1] ? MAG_W'(-n3_q[c]) : MAG_W'(n3_q[c]);
      n5_q[c]  <= n4_q[c];
      sq_q[c]  <= mag_q[c] * mag_q[c];
      dp_q[c]  <= pc4_q[c] * n4_q[c];
      n6_q[c]  <= n5_q[c];
    end
    sqo_q <= SQ_OUT_W'(sqsum >> FRAC_SHIFT);
    dot_q <= SUM_W'(dp_q[0]) + SUM_W'(dp_q[1]) + SUM_W'(dp_q[2]);
  end

  assign sqsum = SQSUM_W'(sq_q[0]) + SQSUM_W'(sq_q[1]) + SQSUM_W'(sq_q[2]);

  always_comb begin
    face_o.vld = vld_q[PIPE_LAT-1];
    face_o.idx = idx_q[PIPE_LAT-1];
    face_o.nx  = n6_q[0];
    face_o.ny  = n6_q[1];
    face_o.nz  = n6_q[2];
    face_o.sq  = sqo_q;
    face_o.dot = dot_q;
  end

endmodule

// ===== hw/rtl/tnv_div9.sv =====
`timescale 1ns / 1ps

module tnv_div9 (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             vld_i,
  input  logic signed [tnv_pkg::SUM_W-1:0] sum_i,
  output tnv_pkg::vol_t                    vol_o
);
  import tnv_pkg::*;

  logic [DIV_LAT-1:0] vld_q;
  logic [SUM_W-1:0]   w_q   [DIV_STEPS+1];
  logic [REM_W-1:0]   rem_q [DIV_STEPS+1];
  logic               neg_q [DIV_STEPS+1];
  logic signed [VOL_W-1:0] vol_q;
  logic               bad_q;
  logic [SUM_W-1:0]   quo;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[DIV_LAT-2:0], vld_i};
    end
  end

  // magnitude and sign
  always_ff @(posedge clk_i) begin
    neg_q[0] <= sum_i[SUM_W-1];
    w_q[0]   <= sum_i[SUM_W-1] ? SUM_W'(-sum_i) : SUM_W'(sum_i);
    rem_q[0] <= '0;
  end

  // restoring long division, a byte of quotient per stage
  for (genvar k = 1; k <= DIV_STEPS; k++) begin : g_step
    logic [SUM_W-1:0] w_d;
    logic [REM_W-1:0] rem_d;

    always_comb begin
      logic [REM_W:0] r5;
      w_d   = w_q[k-1];
      rem_d = rem_q[k-1];
      for (int i = 0; i < DIV_BITS; i++) begin
        r5 = {rem_d, w_d[SUM_W-1]};
        if (r5 >= (REM_W+1)'(DIVISOR)) begin
          rem_d = REM_W'(r5 - (REM_W+1)'(DIVISOR));
          w_d   = {w_d[SUM_W-2:0], 1'b1};
        end else begin
          rem_d = REM_W'(r5);
          w_d   = {w_d[SUM_W-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk_i) begin
      w_q[k]   <= w_d;
      rem_q[k] <= rem_d;
      neg_q[k] <= neg_q[k-1];
    end
  end

  assign quo = w_q[DIV_STEPS];

  always_ff @(posedge clk_i) begin
    vol_q <= neg_q[DIV_STEPS] ? VOL_W'(-quo) : VOL_W'(quo);
    bad_q <= neg_q[DIV_STEPS] || (quo == '0);
  end

  always_comb begin
    vol_o.vld = vld_q[DIV_LAT-1];
    vol_o.vol = vol_q;
    vol_o.bad = bad_q;
  end

endmodule

// ===== hw/rtl/tetrahedron_normals_and_volume.sv =====
// corners are registered on accept; each face passes the face pipeline,
// the face delay line and the output register, and the four result
// words come back to back, one face a cycle on the single result port;
// busy drops once the sequencer is at the last face, so a new element can
// be taken while earlier results are pending; reset clears all valid bits
// and the face sequencer, so nothing is pending; results cannot be stalled
`timescale 1ns / 1ps

module tetrahedron_normals_and_volume (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [15:0] node0_x_i,
  input  logic [15:0] node0_y_i,
  input  logic [15:0] node0_z_i,
  input  logic [15:0] node1_x_i,
  input  logic [15:0] node1_y_i,
  input  logic [15:0] node1_z_i,
  input  logic [15:0] node2_x_i,
  input  logic [15:0] node2_y_i,
  input  logic [15:0] node2_z_i,
  input  logic [15:0] node3_x_i,
  input  logic [15:0] node3_y_i,
  input  logic [15:0] node3_z_i,
  output logic        result_valid_o,
  output logic [1:0]  face_index_o,
  output logic [34:0] normal_x_o,
  output logic [34:0] normal_y_o,
  output logic [34:0] normal_z_o,
  output logic [62:0] normal_sq_length_o,
  output logic [52:0] element_volume_o,
  output logic        bad_size_o,
  output logic        last_face_o
);
  import tnv_pkg::*;

  logic       accept;
  logic       act_q, act_d;
  logic [1:0] cnt_q, cnt_d;
  coord_t     node_q [NODES][DIM];

  face_t      face;
  vol_t       vol;
  logic signed [SUM_W-1:0] sum_q, sum_d;
  logic       sv_q;
  face_t      dly_q [FACE_DLY];
  face_t      out_q;
  logic signed [VOL_W-1:0] vol_q;
  logic       bad_q;

  assign accept = start && !busy;
  assign busy   = act_q && (cnt_q != FACE_LAST);

  // face sequencer
  always_comb begin
    act_d = act_q;
    cnt_d = cnt_q;
    if (act_q) begin
      cnt_d = cnt_q + 2'd1;
      if (cnt_q == FACE_LAST) begin
        act_d = 1'b0;
      end
    end
    if (accept) begin
      act_d = 1'b1;
      cnt_d = FACE_FIRST;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      act_q <= 1'b0;
      cnt_q <= FACE_FIRST;
    end else begin
      act_q <= act_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      node_q[0][0] <= node0_x_i;
      node_q[0][1] <= node0_y_i;
      node_q[0][2] <= node0_z_i;
      node_q[1][0] <= node1_x_i;
      node_q[1][1] <= node1_y_i;
      node_q[1][2] <= node1_z_i;
      node_q[2][0] <= node2_x_i;
      node_q[2][1] <= node2_y_i;
      node_q[2][2] <= node2_z_i;
      node_q[3][0] <= node3_x_i;
      node_q[3][1] <= node3_y_i;
      node_q[3][2] <= node3_z_i;
    end
  end

  tnv_face_pipe u_face_pipe (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .vld_i  (act_q),
    .face_i (cnt_q),
    .node_i (node_q),
    .face_o (face)
  );

  // sum of the corner-by-normal dot products of one element
  always_comb begin
    sum_d = sum_q;
    if (face.vld) begin
      sum_d = (face.idx == FACE_FIRST) ? face.dot : sum_q + face.dot;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sv_q <= 1'b0;
    end else begin
      sv_q <= face.vld && (face.idx == FACE_LAST);
    end
  end

  always_ff @(posedge clk_i) begin
    sum_q <= sum_d;
  end

  tnv_div9 u_div9 (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .vld_i  (sv_q),
    .sum_i  (sum_q),
    .vol_o  (vol)
  );

  // faces wait here until the size of their element is known
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < FACE_DLY; k++) begin
        dly_q[k] <= '0;
      end
      out_q <= '0;
    end else begin
      dly_q[0] <= face;
      for (int k = 1; k < FACE_DLY; k++) begin
        dly_q[k] <= dly_q[k-1];
      end
      out_q <= dly_q[FACE_DLY-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (vol.vld) begin
      vol_q <= vol.vol;
      bad_q <= vol.bad;
    end
  end

  assign result_valid_o     = out_q.vld;
  assign face_index_o       = out_q.idx;
  assign normal_x_o         = out_q.nx;
  assign normal_y_o         = out_q.ny;
  assign normal_z_o         = out_q.nz;
  assign normal_sq_length_o = out_q.sq;
  assign element_volume_o   = vol_q;
  assign bad_size_o         = bad_q;
  assign last_face_o        = (out_q.idx == FACE_LAST);

  a_four_words: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && !last_face_o |=> result_valid_o)
    else $error("result words of an element not contiguous");

  a_face_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && (face_index_o != FACE_FIRST) |->
      $past(result_valid_o) && (face_index_o == 2'($past(face_index_o) + 2'd1)))
    else $error("face words out of order");

  a_vol_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && (face_index_o != FACE_FIRST) |->
      $stable(element_volume_o) && $stable(bad_size_o))
    else $error("size changed within an element");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy)
    else $error("busy not raised after accept");

endmodule

// ===== tb/tetrahedron_normals_and_volume_tb.sv =====
`timescale 1ns / 1ps

module tetrahedron_normals_and_volume_tb;
  import tnv_pkg::*;

  localparam int unsigned RAND_TETRAS = 255;
  localparam int unsigned CYCLE_LIMIT = 100000;
  localparam int unsigned DRAIN_CYCLES = 40;
  localparam int unsigned REPORT_CAP = 100;
  localparam longint SIZE_DIV = DIM * DIM;
  localparam logic [127:0] SQ_MAX = (128'd1 << SQ_OUT_W) - 128'd1;
  localparam int MAXP = 32767;
  localparam int MINN = -32768;

  typedef logic [NODES-1:0][DIM-1:0][COORD_W-1:0] tetra_t;

  typedef struct packed {
    logic [1:0]          idx;
    logic [NRM_W-1:0]    nx;
    logic [NRM_W-1:0]    ny;
    logic [NRM_W-1:0]    nz;
    logic [SQ_OUT_W-1:0] sq;
    logic [VOL_W-1:0]    size;
    logic                bad;
    logic                last;
  } face_word_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [15:0] node0_x_i, node0_y_i, node0_z_i;
  logic [15:0] node1_x_i, node1_y_i, node1_z_i;
  logic [15:0] node2_x_i, node2_y_i, node2_z_i;
  logic [15:0] node3_x_i, node3_y_i, node3_z_i;
  logic        result_valid_o;
  logic [1:0]  face_index_o;
  logic [34:0] normal_x_o;
  logic [34:0] normal_y_o;
  logic [34:0] normal_z_o;
  logic [62:0] normal_sq_length_o;
  logic [52:0] element_volume_o;
  logic        bad_size_o;
  logic        last_face_o;

  tetra_t     drive_t = '0;
  tetra_t     queued_tetras[$];
  face_word_t awaited_faces[$];
  logic       took_item = 1'b0;
  int         tetras_sent = 0;
  int         tetras_accepted = 0;
  int         faces_checked = 0;
  int         flagged_faces = 0;
  int         mismatch_count = 0;
  int         cycle_count = 0;

  assign node0_x_i = drive_t[0][0];
  assign node0_y_i = drive_t[0][1];
  assign node0_z_i = drive_t[0][2];
  assign node1_x_i = drive_t[1][0];
  assign node1_y_i = drive_t[1][1];
  assign node1_z_i = drive_t[1][2];
  assign node2_x_i = drive_t[2][0];
  assign node2_y_i = drive_t[2][1];
  assign node2_z_i = drive_t[2][2];
  assign node3_x_i = drive_t[3][0];
  assign node3_y_i = drive_t[3][1];
  assign node3_z_i = drive_t[3][2];

  tetrahedron_normals_and_volume uut (.*);

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // face f uses edges a x b, f opposite corner f
  function automatic void predict_faces(tetra_t t);
    longint       p [NODES][DIM];
    longint       a [NODES][DIM];
    longint       b [NODES][DIM];
    longint       n [NODES][DIM];
    longint       dot_sum;
    longint       size;
    logic [127:0] sq_acc;
    logic [63:0]  mag;
    face_word_t   w;
    dot_sum = 0;
    for (int i = 0; i < NODES; i++)
      for (int c = 0; c < DIM; c++)
        p[i][c] = longint'($signed(t[i][c]));
    for (int c = 0; c < DIM; c++) begin
      a[0][c] = p[2][c] - p[3][c];
      b[0][c] = p[1][c] - p[3][c];
      a[1][c] = p[0][c] - p[3][c];
      b[1][c] = p[2][c] - p[3][c];
      a[2][c] = p[0][c] - p[1][c];
      b[2][c] = p[3][c] - p[1][c];
      a[3][c] = p[2][c] - p[1][c];
      b[3][c] = p[0][c] - p[1][c];
    end
    for (int f = 0; f < NODES; f++) begin
      n[f][0] = a[f][1] * b[f][2] - a[f][2] * b[f][1];
      n[f][1] = a[f][2] * b[f][0] - a[f][0] * b[f][2];
      n[f][2] = a[f][0] * b[f][1] - a[f][1] * b[f][0];
      for (int c = 0; c < DIM; c++)
        dot_sum += p[f][c] * n[f][c];
    end
    size = dot_sum / SIZE_DIV;
    for (int f = 0; f < NODES; f++) begin
      sq_acc = '0;
      for (int c = 0; c < DIM; c++) begin
        mag = (n[f][c] < 0) ? 64'(-n[f][c]) : 64'(n[f][c]);
        sq_acc += 128'(mag) * 128'(mag);
      end
      sq_acc = sq_acc >> FRAC_SHIFT;
      w.idx  = 2'(f);
      w.nx   = NRM_W'(n[f][0]);
      w.ny   = NRM_W'(n[f][1]);
      w.nz   = NRM_W'(n[f][2]);
      w.sq   = (sq_acc > SQ_MAX) ? SQ_MAX[SQ_OUT_W-1:0] : sq_acc[SQ_OUT_W-1:0];
      w.size = VOL_W'(size);
      w.bad  = (size <= 0);
      w.last = (2'(f) == FACE_LAST);
      awaited_faces = {awaited_faces, w};
    end
  endfunction

  function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
    if (got !== want) begin
      mismatch_count++;
      if (mismatch_count <= REPORT_CAP)
        $error("%s: expected %h, got %h", name, want, got);
    end
  endfunction

  task automatic add_tetra(input int x0, y0, z0, x1, y1, z1, x2, y2, z2, x3, y3, z3);
    tetra_t t;
    t[0][0] = 16'(x0); t[0][1] = 16'(y0); t[0][2] = 16'(z0);
    t[1][0] = 16'(x1); t[1][1] = 16'(y1); t[1][2] = 16'(z1);
    t[2][0] = 16'(x2); t[2][1] = 16'(y2); t[2][2] = 16'(z2);
    t[3][0] = 16'(x3); t[3][1] = 16'(y3); t[3][2] = 16'(z3);
    queued_tetras = {queued_tetras, t};
  endtask

  // driver: a word is held until it is taken
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      start <= 1'b0;
    end else if (start && !took_item) begin
      start <= 1'b1;
    end else if (queued_tetras.size() > 0 &&
                 ((tetras_sent >= 100 && tetras_sent < 160) ||
                  $urandom_range(99) >= 34)) begin
      drive_t <= queued_tetras.pop_front();
      start <= 1'b1;
      tetras_sent++;
    end else begin
      start <= 1'b0;
    end
  end

  // monitor
  always @(posedge clk_i) begin
    face_word_t want;
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("tetrahedron_normals_and_volume: mismatch");
      $finish;
    end
    if (rst_ni) begin
      if (result_valid_o) begin
        if (awaited_faces.size() == 0) begin
          mismatch_count++;
          $error("unexpected face word, face_index %0d", face_index_o);
        end else begin
          want = awaited_faces.pop_front();
          check_field("face_index", 64'(want.idx), 64'(face_index_o));
          check_field("normal_x", 64'(want.nx), 64'(normal_x_o));
          check_field("normal_y", 64'(want.ny), 64'(normal_y_o));
          check_field("normal_z", 64'(want.nz), 64'(normal_z_o));
          check_field("normal_sq_length", 64'(want.sq), 64'(normal_sq_length_o));
          check_field("element_volume", 64'(want.size), 64'(element_volume_o));
          check_field("bad_size", 64'(want.bad), 64'(bad_size_o));
          check_field("last_face", 64'(want.last), 64'(last_face_o));
          faces_checked++;
          if (want.bad)
            flagged_faces++;
        end
      end
      took_item <= start && !busy;
      if (start && !busy) begin
        predict_faces(drive_t);
        tetras_accepted++;
      end
    end
  end

  initial begin
    tetra_t t;
    logic [DIM-1:0][COORD_W-1:0] corner;
    int kind;
    int span;
    int v;
    // directed shapes
    add_tetra(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    add_tetra(0, 0, 0, 1, 0, 0, 0, 1, 0, 0, 0, 1);
    add_tetra(0, 0, 0, 0, 1, 0, 1, 0, 0, 0, 0, 1);
    add_tetra(0, 0, 0, 256, 0, 0, 0, 256, 0, 0, 0, 256);
    add_tetra(0, 0, 0, 0, 256, 0, 256, 0, 0, 0, 0, 256);
    add_tetra(MINN, MINN, MINN, MAXP, MINN, MINN, MINN, MAXP, MINN, MINN, MINN, MAXP);
    add_tetra(MINN, MINN, MINN, MINN, MAXP, MINN, MAXP, MINN, MINN, MINN, MINN, MAXP);
    add_tetra(MAXP, MAXP, MAXP, MAXP, MAXP, MAXP, MAXP, MAXP, MAXP, MAXP, MAXP, MAXP);
    add_tetra(MINN, MINN, MINN, MINN, MINN, MINN, MINN, MINN, MINN, MINN, MINN, MINN);
    add_tetra(MAXP, MINN, MAXP, MINN, MAXP, MINN, MAXP, MAXP, MINN, MINN, MINN, MAXP);
    add_tetra(MINN, MAXP, MINN, MAXP, MINN, MAXP, MINN, MINN, MAXP, MAXP, MAXP, MINN);
    add_tetra(0, 0, 0, 100, 100, 100, 200, 200, 200, -300, -300, -300);
    add_tetra(1, 2, 77, 500, -3, 77, -40, 900, 77, 12, 12, 77);
    add_tetra(5, 6, 7, 5, 6, 7, 100, 0, 0, 0, 100, 0);
    add_tetra(-1, -1, -1, 0, -1, -1, -1, 0, -1, -1, -1, 0);
    add_tetra(MAXP, 0, 0, 0, MAXP, 0, 0, 0, MAXP, MINN, MINN, MINN);
    add_tetra(0, MAXP, 0, MAXP, 0, 0, 0, 0, MAXP, MINN, MINN, MINN);
    // random shapes: full range, mid, small and tiny spans
    for (int k = 0; k < RAND_TETRAS; k++) begin
      kind = $urandom_range(99);
      span = (kind < 45) ? 0 : (kind < 65) ? 1024 : (kind < 75) ? 4 : 8192;
      for (int i = 0; i < NODES; i++)
        for (int c = 0; c < DIM; c++) begin
          if (span == 0) begin
            t[i][c] = 16'($urandom);
          end else begin
            v = int'($urandom_range(span)) - span / 2;
            t[i][c] = 16'(v);
          end
        end
      if ($urandom_range(3) == 0) begin
        corner = t[1];
        t[1] = t[2];
        t[2] = corner;
      end
      if (kind >= 90) begin
        case ($urandom_range(2))
          0: t[3] = t[$urandom_range(2)];
          1: for (int i = 1; i < NODES; i++) t[i][2] = t[0][2];
          default: for (int i = 1; i < NODES; i++) t[i] = t[0];
        endcase
      end
      queued_tetras = {queued_tetras, t};
    end

    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    while (queued_tetras.size() > 0 || start) @(posedge clk_i);
    while (awaited_faces.size() > 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("%0d tetrahedra taken: corner extremes, reversed, flat and random shapes",
             tetras_accepted);
    $display("%0d face words checked, %0d of them flagged with a non-positive size",
             faces_checked, flagged_faces);
    if (mismatch_count == 0) begin
      $display("tetrahedron_normals_and_volume: match");
    end else begin
      $display("tetrahedron_normals_and_volume: mismatch");
    end
    $finish;
  end

endmodule
